// ===== design/hvps_pkg.sv =====
// ----------------------------------------------------------------------------
// hvps_pkg
// Shared codes, register layout and payload types of the pulse test sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package hvps_pkg;

   // item kinds
   localparam logic [1:0] FUNC_TICK    = 2'd0;
   localparam logic [1:0] FUNC_COMMAND = 2'd1;
   localparam logic [1:0] FUNC_OUTCOME = 2'd2;

   // host commands
   localparam logic [2:0] CMD_POWER_ON  = 3'd0;
   localparam logic [2:0] CMD_POWER_OFF = 3'd1;
   localparam logic [2:0] CMD_START     = 3'd2;
   localparam logic [2:0] CMD_STOP      = 3'd3;
   localparam logic [2:0] CMD_CALIBRATE = 3'd4;
   localparam logic [2:0] CMD_CLR_FAULT = 3'd5;
   localparam logic [2:0] CMD_CLR_WARN  = 3'd6;

   // device state
   localparam logic [1:0] DEV_NONE  = 2'd0;
   localparam logic [1:0] DEV_READY = 2'd1;
   localparam logic [1:0] DEV_BUSY  = 2'd2;
   localparam logic [1:0] DEV_FAULT = 2'd3;

   // sub-state
   localparam logic [2:0] SUB_NONE    = 3'd0;
   localparam logic [2:0] SUB_POWERUP = 3'd1;
   localparam logic [2:0] SUB_PREPARE = 3'd2;
   localparam logic [2:0] SUB_DELAY   = 3'd3;
   localparam logic [2:0] SUB_PULSE   = 3'd4;

   // user error
   localparam logic [1:0] UE_NONE      = 2'd0;
   localparam logic [1:0] UE_BLOCKED   = 2'd1;
   localparam logic [1:0] UE_NOT_READY = 2'd2;

   // operation result
   localparam logic [1:0] RES_NONE = 2'd0;
   localparam logic [1:0] RES_OK   = 2'd1;
   localparam logic [1:0] RES_FAIL = 2'd2;

   // stop problem
   localparam logic [1:0] PRB_NONE   = 2'd0;
   localparam logic [1:0] PRB_SHORT  = 2'd1;
   localparam logic [1:0] PRB_CUTOFF = 2'd2;

   // fault reason
   localparam logic FLT_NONE      = 1'b0;
   localparam logic FLT_FOLLOWING = 1'b1;

   // logic command strobe
   localparam logic [1:0] LC_NONE    = 2'd0;
   localparam logic [1:0] LC_STOP    = 2'd1;
   localparam logic [1:0] LC_PREPARE = 2'd2;
   localparam logic [1:0] LC_CALIB   = 2'd3;

   // register map
   localparam int unsigned CSR_ADDR_BITS = 4;
   localparam logic [1:0] REG_SUPPLY_TIME = 2'd0;
   localparam logic [1:0] REG_DELAY_TIME  = 2'd1;
   localparam logic [1:0] REG_PAUSE_TIME  = 2'd2;

   typedef struct packed {
      logic [15:0] supply_active_time;
      logic [15:0] start_delay_time;
      logic [15:0] after_pulse_pause_time;
   } cfg_type;

   typedef struct packed {
      logic [1:0] dev_state;
      logic [2:0] sub_state;
      logic [1:0] user_error;
      logic [1:0] op_result;
      logic [1:0] problem;
      logic       fault_reason;
      logic       supply_enable;
      logic       measure_led;
      logic       line_sync;
      logic       pulse_start;
      logic [1:0] logic_command;
      logic       warning_clear;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/hvps_req_if.sv =====
// ----------------------------------------------------------------------------
// hvps_req_if
// Input channel: tick, host command or pulse sample outcome.
// ----------------------------------------------------------------------------
`default_nettype none

interface hvps_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [2:0] command;
   logic       excess_current;
   logic       regulator_done;
   logic       following_error;

   modport source (
      output valid, func, command, excess_current, regulator_done, following_error,
      input  ready
   );

   modport sink (
      input  valid, func, command, excess_current, regulator_done, following_error,
      output ready
   );
endinterface

`default_nettype wire

// ===== design/hvps_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hvps_rsp_if
// Result channel: device state, codes, output levels and strobes.
// ----------------------------------------------------------------------------
`default_nettype none

interface hvps_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] dev_state;
   logic [2:0] sub_state;
   logic [1:0] user_error;
   logic [1:0] op_result;
   logic [1:0] problem;
   logic       fault_reason;
   logic       supply_enable;
   logic       measure_led;
   logic       line_sync;
   logic       pulse_start;
   logic [1:0] logic_command;
   logic       warning_clear;

   modport source (
      output valid, dev_state, sub_state, user_error, op_result, problem, fault_reason,
             supply_enable, measure_led, line_sync, pulse_start, logic_command,
             warning_clear,
      input  ready
   );

   modport sink (
      input  valid, dev_state, sub_state, user_error, op_result, problem, fault_reason,
             supply_enable, measure_led, line_sync, pulse_start, logic_command,
             warning_clear,
      output ready
   );
endinterface

`default_nettype wire

// ===== design/hvps_csr.sv =====
// ----------------------------------------------------------------------------
// hvps_csr
// APB-style register block holding the three timing registers.
// ----------------------------------------------------------------------------
`default_nettype none

module hvps_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [hvps_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output      logic [31:0]                        csr_prdata,
   output      logic                               csr_pready,
   output      hvps_pkg::cfg_type                  cfg
);

   hvps_pkg::cfg_type cfg_ff;
   hvps_pkg::cfg_type cfg_in;
   logic [1:0]        reg_index;
   logic              wr_en;

   assign reg_index  = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            hvps_pkg::REG_SUPPLY_TIME: cfg_in.supply_active_time     = csr_pwdata[15:0];
            hvps_pkg::REG_DELAY_TIME:  cfg_in.start_delay_time       = csr_pwdata[15:0];
            hvps_pkg::REG_PAUSE_TIME:  cfg_in.after_pulse_pause_time = csr_pwdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         hvps_pkg::REG_SUPPLY_TIME: csr_prdata = {16'd0, cfg_ff.supply_active_time};
         hvps_pkg::REG_DELAY_TIME:  csr_prdata = {16'd0, cfg_ff.start_delay_time};
         hvps_pkg::REG_PAUSE_TIME:  csr_prdata = {16'd0, cfg_ff.after_pulse_pause_time};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/hv_pulse_test_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// hv_pulse_test_sequencer_unit
// High-voltage pulse test sequencer: ticks, host commands and pulse outcomes
// drive the device state, timing deadlines and supply/sync output levels.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | payload
//  req_if   | in  | valid/ready          | func, command, excess_current, ...
//  rsp_if   | out | valid/ready          | dev_state, sub_state, codes, levels
//  csr_*    | in  | psel/penable, pready | 4-bit byte address, 32-bit data
//
//  one item per cycle while the result is not stalled; each item yields one result in the next cycle
//  the state update and result are computed in one pass from the state
//  registers and the input payload, then registered together
//  a stalled result holds the output register; a new item is taken in the
//  same cycle the held result leaves
//  reset clears state, deadlines, time counter, result valid flag and CSR timing registers
// ----------------------------------------------------------------------------
`default_nettype none

module hv_pulse_test_sequencer_unit #(
   parameter int unsigned TIME_BITS = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   hvps_req_if.sink                                req_if,
   hvps_rsp_if.source                              rsp_if,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [hvps_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output      logic [31:0]                        csr_prdata,
   output      logic                               csr_pready
);

   hvps_pkg::cfg_type cfg;

   logic [1:0]           state_ff,   state_in;
   logic [2:0]           sub_ff,     sub_in;
   logic [TIME_BITS-1:0] time_ff,    time_in;
   logic [TIME_BITS-1:0] prep_dl_ff, prep_dl_in;
   logic [TIME_BITS-1:0] pause_dl_ff, pause_dl_in;
   logic [1:0]           result_ff,  result_in;
   logic [1:0]           problem_ff, problem_in;
   logic                 fault_ff,   fault_in;
   logic                 supply_ff,  supply_in;
   logic                 led_ff,     led_in;
   logic                 sync_ff,    sync_in;

   hvps_pkg::rsp_type    rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [TIME_BITS-1:0] time_inc;
   logic [TIME_BITS:0]   supply_sum;
   logic [TIME_BITS:0]   delay_sum;
   logic                 dl_passed;
   logic [1:0]           user_err;
   logic [1:0]           logic_cmd;
   logic                 pulse_strobe;
   logic                 warn_clr;
   logic                 accept;

   hvps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign time_inc     = time_ff + TIME_BITS'(1);
   // a freshly armed deadline is already passed only when its sum carries out
   assign supply_sum   = {1'b0, time_inc} + (TIME_BITS+1)'(cfg.supply_active_time);
   assign delay_sum    = {1'b0, time_inc} + (TIME_BITS+1)'(cfg.start_delay_time);

   always_comb begin
      state_in     = state_ff;
      sub_in       = sub_ff;
      time_in      = time_ff;
      prep_dl_in   = prep_dl_ff;
      pause_dl_in  = pause_dl_ff;
      result_in    = result_ff;
      problem_in   = problem_ff;
      fault_in     = fault_ff;
      supply_in    = supply_ff;
      led_in       = led_ff;
      sync_in      = sync_ff;
      user_err     = hvps_pkg::UE_NONE;
      logic_cmd    = hvps_pkg::LC_NONE;
      pulse_strobe = 1'b0;
      warn_clr     = 1'b0;
      dl_passed    = 1'b0;

      case (req_if.func)
         hvps_pkg::FUNC_TICK: begin
            time_in = time_inc;
            case (sub_ff)
               hvps_pkg::SUB_POWERUP: begin
                  state_in = hvps_pkg::DEV_READY;
                  sub_in   = hvps_pkg::SUB_NONE;
               end
               hvps_pkg::SUB_PREPARE: begin
                  if (time_inc > pause_dl_ff) begin
                     // zero deadline means not yet armed
                     if (prep_dl_ff == '0) begin
                        supply_in  = 1'b1;
                        led_in     = 1'b1;
                        prep_dl_in = supply_sum[TIME_BITS-1:0];
                        dl_passed  = supply_sum[TIME_BITS];
                     end else begin
                        dl_passed  = time_inc > prep_dl_ff;
                     end
                     if (dl_passed) begin
                        prep_dl_in = '0;
                        supply_in  = 1'b0;
                        state_in   = hvps_pkg::DEV_BUSY;
                        sub_in     = hvps_pkg::SUB_DELAY;
                     end
                  end
               end
               hvps_pkg::SUB_DELAY: begin
                  if (prep_dl_ff == '0) begin
                     prep_dl_in = delay_sum[TIME_BITS-1:0];
                     dl_passed  = delay_sum[TIME_BITS];
                  end else begin
                     dl_passed  = time_inc > prep_dl_ff;
                  end
                  if (dl_passed) begin
                     prep_dl_in   = '0;
                     state_in     = hvps_pkg::DEV_BUSY;
                     sub_in       = hvps_pkg::SUB_PULSE;
                     sync_in      = 1'b1;
                     pulse_strobe = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end

         hvps_pkg::FUNC_COMMAND: begin
            case (req_if.command)
               hvps_pkg::CMD_POWER_ON: begin
                  if (state_ff == hvps_pkg::DEV_NONE) begin
                     state_in = hvps_pkg::DEV_BUSY;
                     sub_in   = hvps_pkg::SUB_POWERUP;
                  end else if (state_ff != hvps_pkg::DEV_READY) begin
                     user_err = hvps_pkg::UE_BLOCKED;
                  end
               end
               hvps_pkg::CMD_POWER_OFF: begin
                  if (state_ff == hvps_pkg::DEV_READY) begin
                     logic_cmd = hvps_pkg::LC_STOP;
                     state_in  = hvps_pkg::DEV_NONE;
                     sub_in    = hvps_pkg::SUB_NONE;
                  end else if (state_ff != hvps_pkg::DEV_NONE) begin
                     user_err = hvps_pkg::UE_BLOCKED;
                  end
               end
               hvps_pkg::CMD_START: begin
                  if (state_ff == hvps_pkg::DEV_READY) begin
                     fault_in   = hvps_pkg::FLT_NONE;
                     problem_in = hvps_pkg::PRB_NONE;
                     result_in  = hvps_pkg::RES_NONE;
                     warn_clr   = 1'b1;
                     logic_cmd  = hvps_pkg::LC_PREPARE;
                     state_in   = hvps_pkg::DEV_BUSY;
                     sub_in     = hvps_pkg::SUB_PREPARE;
                  end else if (state_ff == hvps_pkg::DEV_BUSY) begin
                     user_err = hvps_pkg::UE_BLOCKED;
                  end else begin
                     user_err = hvps_pkg::UE_NOT_READY;
                  end
               end
               hvps_pkg::CMD_STOP: begin
                  // deadline and supply levels stay as they are
                  if (state_ff == hvps_pkg::DEV_BUSY) begin
                     logic_cmd = hvps_pkg::LC_STOP;
                     state_in  = hvps_pkg::DEV_READY;
                     sub_in    = hvps_pkg::SUB_NONE;
                  end
               end
               hvps_pkg::CMD_CALIBRATE: begin
                  if (state_ff == hvps_pkg::DEV_READY) begin
                     logic_cmd = hvps_pkg::LC_CALIB;
                     state_in  = hvps_pkg::DEV_BUSY;
                     sub_in    = hvps_pkg::SUB_PREPARE;
                  end else begin
                     user_err = hvps_pkg::UE_BLOCKED;
                  end
               end
               hvps_pkg::CMD_CLR_FAULT: begin
                  if (state_ff == hvps_pkg::DEV_FAULT) begin
                     state_in = hvps_pkg::DEV_NONE;
                     sub_in   = hvps_pkg::SUB_NONE;
                     fault_in = hvps_pkg::FLT_NONE;
                  end
               end
               hvps_pkg::CMD_CLR_WARN: begin
                  warn_clr = 1'b1;
               end
               default: begin
               end
            endcase
         end

         hvps_pkg::FUNC_OUTCOME: begin
            if ((sub_ff == hvps_pkg::SUB_PULSE) &&
                (req_if.excess_current || req_if.regulator_done)) begin
               logic_cmd   = hvps_pkg::LC_STOP;
               sync_in     = 1'b0;
               led_in      = 1'b0;
               pause_dl_in = time_ff + TIME_BITS'(cfg.after_pulse_pause_time);
               state_in    = hvps_pkg::DEV_READY;
               sub_in      = hvps_pkg::SUB_NONE;
               if (req_if.excess_current && req_if.following_error) begin
                  result_in  = hvps_pkg::RES_FAIL;
                  problem_in = hvps_pkg::PRB_SHORT;
               end else if (req_if.excess_current) begin
                  result_in  = hvps_pkg::RES_OK;
                  problem_in = hvps_pkg::PRB_CUTOFF;
               end else if (req_if.following_error) begin
                  result_in = hvps_pkg::RES_FAIL;
                  state_in  = hvps_pkg::DEV_FAULT;
                  fault_in  = hvps_pkg::FLT_FOLLOWING;
               end else begin
                  result_in = hvps_pkg::RES_OK;
               end
            end
         end

         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_in.dev_state     = state_in;
      rsp_in.sub_state     = sub_in;
      rsp_in.user_error    = user_err;
      rsp_in.op_result     = result_in;
      rsp_in.problem       = problem_in;
      rsp_in.fault_reason  = fault_in;
      rsp_in.supply_enable = supply_in;
      rsp_in.measure_led   = led_in;
      rsp_in.line_sync     = sync_in;
      rsp_in.pulse_start   = pulse_strobe;
      rsp_in.logic_command = logic_cmd;
      rsp_in.warning_clear = warn_clr;
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_if.ready);

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= hvps_pkg::DEV_NONE;
         sub_ff      <= hvps_pkg::SUB_NONE;
         time_ff     <= '0;
         prep_dl_ff  <= '0;
         pause_dl_ff <= '0;
         result_ff   <= hvps_pkg::RES_NONE;
         problem_ff  <= hvps_pkg::PRB_NONE;
         fault_ff    <= hvps_pkg::FLT_NONE;
         supply_ff   <= 1'b0;
         led_ff      <= 1'b0;
         sync_ff     <= 1'b0;
      end else if (accept) begin
         state_ff    <= state_in;
         sub_ff      <= sub_in;
         time_ff     <= time_in;
         prep_dl_ff  <= prep_dl_in;
         pause_dl_ff <= pause_dl_in;
         result_ff   <= result_in;
         problem_ff  <= problem_in;
         fault_ff    <= fault_in;
         supply_ff   <= supply_in;
         led_ff      <= led_in;
         sync_ff     <= sync_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.dev_state     = rsp_ff.dev_state;
   assign rsp_if.sub_state     = rsp_ff.sub_state;
   assign rsp_if.user_error    = rsp_ff.user_error;
   assign rsp_if.op_result     = rsp_ff.op_result;
   assign rsp_if.problem       = rsp_ff.problem;
   assign rsp_if.fault_reason  = rsp_ff.fault_reason;
   assign rsp_if.supply_enable = rsp_ff.supply_enable;
   assign rsp_if.measure_led   = rsp_ff.measure_led;
   assign rsp_if.line_sync     = rsp_ff.line_sync;
   assign rsp_if.pulse_start   = rsp_ff.pulse_start;
   assign rsp_if.logic_command = rsp_ff.logic_command;
   assign rsp_if.warning_clear = rsp_ff.warning_clear;

endmodule

`default_nettype wire
